>>> rtl/utf8_stream_decoder_assert.svh
// Assertion macros shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define USD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define USD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/usd_pkg.sv
// Types, constants and helpers shared by the UTF-8 stream decoder.
package usd_pkg;

  localparam int unsigned CP_W        = 31;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned MAX_RESULTS = 6;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 31'h0000FFFD;

  typedef struct packed {
    logic [CNT_W-1:0] reps;
    logic             has_value;
    logic [CP_W-1:0]  value;
  } job_t;

  function automatic logic [CP_W-1:0] min_value(input logic [CNT_W-1:0] total);
    logic [CP_W-1:0] v;
    unique case (total)
      3'd1:    v = 31'h00000080;
      3'd2:    v = 31'h00000800;
      3'd3:    v = 31'h00010000;
      3'd4:    v = 31'h00200000;
      3'd5:    v = 31'h04000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// The first result of a byte is registered and appears the cycle after the byte is accepted.
// One byte per cycle while each byte gives at most one result and results are taken;
// a byte giving several results holds the result register until its last one is taken.
// Bytes that give no result pass through without using the result register.
// Reset clears the open sequence and drops any results not yet delivered.
module utf8_stream_decoder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_ready,
  input  logic [7:0]               data_byte,
  input  logic                     stream_end,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [usd_pkg::CP_W-1:0] code_point,
  output logic                     is_replacement,
  output logic                     run_last
);

  usd_pkg::job_t job;
  logic          accept;
  logic          load;
  logic          can_load;

  assign byte_ready = can_load;
  assign accept     = byte_valid && byte_ready;
  assign load       = accept && (job.reps != '0 || job.has_value);

  usd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .job        (job)
  );

  usd_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .job            (job),
    .can_load       (can_load),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .run_last       (run_last)
  );

endmodule

>>> rtl/usd_decode.sv
// Sequence state and per-byte decode into a result job.
`include "utf8_stream_decoder_assert.svh"

module usd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output usd_pkg::job_t     job
);

  logic [usd_pkg::CNT_W-1:0] pending_total, pending_total_next;
  logic [usd_pkg::CNT_W-1:0] pending_seen, pending_seen_next;
  logic [usd_pkg::CP_W-1:0]  value_accumulator, value_accumulator_next;

  logic                      lead_rep;
  logic                      lead_has;
  logic [usd_pkg::CP_W-1:0]  lead_val;
  logic                      lead_open;
  logic [usd_pkg::CNT_W-1:0] lead_need;
  logic [usd_pkg::CP_W-1:0]  lead_pay;
  logic [usd_pkg::CP_W-1:0]  acc_shift;
  logic [usd_pkg::CNT_W-1:0] seen_inc;

  always_comb begin
    lead_rep  = 1'b0;
    lead_has  = 1'b0;
    lead_val  = '0;
    lead_open = 1'b0;
    lead_need = '0;
    lead_pay  = '0;
    if (!data_byte[7]) begin
      lead_has = 1'b1;
      lead_val = usd_pkg::CP_W'(data_byte);
    end else if (data_byte[7:6] == 2'b10 || data_byte[7:1] == 7'h7F) begin
      lead_rep = 1'b1;
    end else begin
      priority if (!data_byte[5]) begin
        lead_need = 3'd1;
        lead_pay  = usd_pkg::CP_W'(data_byte[4:0]);
      end else if (!data_byte[4]) begin
        lead_need = 3'd2;
        lead_pay  = usd_pkg::CP_W'(data_byte[3:0]);
      end else if (!data_byte[3]) begin
        lead_need = 3'd3;
        lead_pay  = usd_pkg::CP_W'(data_byte[2:0]);
      end else if (!data_byte[2]) begin
        lead_need = 3'd4;
        lead_pay  = usd_pkg::CP_W'(data_byte[1:0]);
      end else begin
        lead_need = 3'd5;
        lead_pay  = usd_pkg::CP_W'(data_byte[0]);
      end
      if (stream_end) begin
        lead_rep = 1'b1;
      end else begin
        lead_open = 1'b1;
      end
    end
  end

  always_comb begin
    acc_shift = {value_accumulator[usd_pkg::CP_W-7:0], data_byte[5:0]};
    seen_inc  = pending_seen + 3'd1;

    job                    = '0;
    pending_total_next     = pending_total;
    pending_seen_next      = pending_seen;
    value_accumulator_next = value_accumulator;

    if (pending_total == '0 || data_byte[7:6] != 2'b10) begin
      if (pending_total != '0) begin
        job.reps = seen_inc + usd_pkg::CNT_W'(lead_rep);
      end else begin
        job.reps = usd_pkg::CNT_W'(lead_rep);
      end
      job.has_value = lead_has;
      job.value     = lead_val;
      if (lead_open) begin
        pending_total_next     = lead_need;
        pending_seen_next      = '0;
        value_accumulator_next = lead_pay;
      end else begin
        pending_total_next     = '0;
        pending_seen_next      = '0;
        value_accumulator_next = '0;
      end
    end else begin
      value_accumulator_next = acc_shift;
      pending_seen_next      = seen_inc;
      if (seen_inc >= pending_total) begin
        if (acc_shift < usd_pkg::min_value(pending_total)) begin
          job.reps = pending_total + 3'd1;
        end else begin
          job.has_value = 1'b1;
          job.value     = acc_shift;
        end
        pending_total_next     = '0;
        pending_seen_next      = '0;
        value_accumulator_next = '0;
      end else if (stream_end) begin
        job.reps               = seen_inc + 3'd1;
        pending_total_next     = '0;
        pending_seen_next      = '0;
        value_accumulator_next = '0;
      end
    end

    if (stream_end) begin
      pending_total_next     = '0;
      pending_seen_next      = '0;
      value_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_total     <= '0;
      pending_seen      <= '0;
      value_accumulator <= '0;
    end else if (accept) begin
      pending_total     <= pending_total_next;
      pending_seen      <= pending_seen_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  `USD_ASSERT(a_total_range, pending_total <= 3'd5, "sequence length out of range")
  `USD_ASSERT(a_seen_below_total, (pending_total != '0) |-> (pending_seen < pending_total),
              "continuation count reached sequence length while open")
  `USD_ASSERT(a_end_closes, (accept && stream_end) |=> (pending_total == '0),
              "sequence still open after end of stream")

endmodule

>>> rtl/usd_emit.sv
// Result register that plays out one job as a run of result items.
`include "utf8_stream_decoder_assert.svh"

module usd_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  usd_pkg::job_t            job,
  output logic                     can_load,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [usd_pkg::CP_W-1:0] code_point,
  output logic                     is_replacement,
  output logic                     run_last
);

  logic [usd_pkg::CNT_W-1:0] reps_left;
  logic                      has_val;
  logic [usd_pkg::CP_W-1:0]  value;
  logic                      taken;

  assign result_valid   = (reps_left != '0) || has_val;
  assign is_replacement = (reps_left != '0);
  assign code_point     = (reps_left != '0) ? usd_pkg::REPLACEMENT_CP : value;
  assign run_last       = (reps_left == '0) || (reps_left == 3'd1 && !has_val);
  assign taken          = result_valid && result_ready;
  assign can_load       = !result_valid || (result_ready && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      reps_left <= '0;
      has_val   <= 1'b0;
    end else if (load) begin
      reps_left <= job.reps;
      has_val   <= job.has_value;
      value     <= job.value;
    end else if (taken) begin
      if (reps_left != '0) begin
        reps_left <= reps_left - 3'd1;
      end else begin
        has_val <= 1'b0;
      end
    end
  end

  `USD_ASSERT(a_count_range, reps_left <= 3'(usd_pkg::MAX_RESULTS),
              "replacement count out of range")
  `USD_ASSERT(a_load_shows, load |=> result_valid, "loaded job shows no result")
  `USD_ASSERT(a_last_drains, (taken && run_last && !load) |=> !result_valid,
              "result still shown after last item of a run")
  `USD_ASSERT_ALWAYS(a_load_safe, load |-> can_load, "job loaded over a pending run")

endmodule
